/* hdl/sat_pkg.sv */
// shared types and constants of the summed-area table query block
`default_nettype none

package sat_pkg;

  // field widths
  localparam int ELEM_W  = 16;
  localparam int SUM_W   = 28;
  localparam int RSUM_W  = 22;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 2;

  // table geometry, one row of the store per matrix row
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;

  // packed channel widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_READY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_CORNER = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // table read address source
  typedef enum logic [2:0] {
    RD_ABOVE = 3'd0,
    RD_Q0    = 3'd1,
    RD_Q1    = 3'd2,
    RD_Q2    = 3'd3,
    RD_Q3    = 3'd4
  } rd_sel_t;

  // accumulator operation on the read data arriving this cycle
  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_T0   = 2'd1,
    ACC_T1   = 2'd2,
    ACC_T2   = 2'd3
  } acc_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic    accept;
    logic    is_query;
    logic    ld_write;
    rd_sel_t rd_sel;
    acc_op_t acc_op;
    logic    out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage : sat_pkg

`default_nettype wire

/* hdl/summed_area_table_query.sv */
// top level of the summed-area table query block
//
// Load items (tuser 0) fill a 64 x 64 prefix-sum table held in one synchronous
// RAM with a registered read port, in row-major order over the configured rows
// and columns; a load reads the entry above, then writes the new entry.
// Query items (tuser 1) make four corner reads, one per cycle, through the same
// RAM read port, and the last data is summed into the output register once it
// is free; the result then waits there for out_tready while the next item is taken.
// Queries before a full matrix has been loaded give status 1, inverted or
// out-of-size corners give status 2, both with a zero sum. The table needs no
// clearing after reset; a write to either count register restarts loading at row 0, column 0.
`default_nettype none

module summed_area_table_query (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: element[15:0], row_top[21:16], col_left[27:22],
  //           row_bottom[33:28], col_right[39:34]
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [sat_pkg::IN_DATA_W-1:0]       in_tdata,
  // in_tuser: req_type[0]
  input  wire logic                                in_tuser,
  // out_tdata: region_sum[27:0], zero fill above
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [sat_pkg::OUT_DATA_W-1:0]      out_tdata,
  // out_tuser: status[1:0]
  output logic      [sat_pkg::STAT_W-1:0]          out_tuser,
  // register write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sat_pkg::CNT_W-1:0]           cfg_data
);

  sat_pkg::cmd_t  cmd;
  sat_pkg::stat_t dp_stat;

  // registers are always writable
  assign cfg_ready = 1'b1;

  sat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  sat_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .dp_stat    (dp_stat),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule : summed_area_table_query

`default_nettype wire

/* hdl/sat_ram.sv */
// generic single-clock ram, one write and one registered read port
`default_nettype none

module sat_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read, old data on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule : sat_ram

`default_nettype wire

/* hdl/sat_ctrl.sv */
// sequencing state machine for loads and rectangle queries
`default_nettype none

module sat_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tuser,
  output logic               in_tready,
  input  wire sat_pkg::stat_t dp_stat,
  output sat_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LD_WR = 6'b000010,
    S_Q1    = 6'b000100,
    S_Q2    = 6'b001000,
    S_Q3    = 6'b010000,
    S_QFIN  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.is_query = (in_tuser == sat_pkg::REQ_QUERY);
    cmd.ld_write = 1'b0;
    cmd.rd_sel   = sat_pkg::RD_ABOVE;
    cmd.acc_op   = sat_pkg::ACC_HOLD;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = accept;
        cmd.rd_sel = (in_tuser == sat_pkg::REQ_QUERY) ? sat_pkg::RD_Q0 : sat_pkg::RD_ABOVE;
        if (accept) begin
          state_nxt = (in_tuser == sat_pkg::REQ_QUERY) ? S_Q1 : S_LD_WR;
        end
      end
      S_LD_WR: begin
        cmd.ld_write = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_Q1: begin
        cmd.rd_sel = sat_pkg::RD_Q1;
        cmd.acc_op = sat_pkg::ACC_T0;
        state_nxt  = S_Q2;
      end
      S_Q2: begin
        cmd.rd_sel = sat_pkg::RD_Q2;
        cmd.acc_op = sat_pkg::ACC_T1;
        state_nxt  = S_Q3;
      end
      S_Q3: begin
        cmd.rd_sel = sat_pkg::RD_Q3;
        cmd.acc_op = sat_pkg::ACC_T2;
        state_nxt  = S_QFIN;
      end
      S_QFIN: begin
        // hold the last address so its data stays put while the output is busy
        cmd.rd_sel   = sat_pkg::RD_Q3;
        cmd.out_load = dp_stat.out_free;
        if (dp_stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : sat_ctrl

`default_nettype wire

/* hdl/sat_datapath.sv */
// load counters, prefix table, query accumulator and output register
`default_nettype none

module sat_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire sat_pkg::cmd_t                      cmd,
  output sat_pkg::stat_t                          dp_stat,
  input  wire logic [sat_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                               cfg_valid,
  input  wire logic [sat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sat_pkg::CNT_W-1:0]          cfg_data,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [sat_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic      [sat_pkg::STAT_W-1:0]         out_tuser
);

  localparam int IW = sat_pkg::IDX_W;
  localparam int CW = sat_pkg::CNT_W;
  localparam int SW = sat_pkg::SUM_W;
  localparam int RW = sat_pkg::RSUM_W;
  localparam int EW = sat_pkg::ELEM_W;

  // configuration and load state
  logic [CW-1:0]        row_cnt_r, col_cnt_r;
  logic [CW-1:0]        rows, cols;
  logic [IW-1:0]        ld_row_r, ld_col_r;
  logic signed [RW-1:0] rsum_r;
  logic                 ready_r;
  logic                 cfg_hit;

  // latched item
  logic [EW-1:0]        elem_r;
  logic [IW-1:0]        rt_r, cl_r, rb_r, cr_r;
  logic [sat_pkg::STAT_W-1:0] qstat_r, qstat_nxt;

  // accumulator and output
  logic signed [SW-1:0] acc_r, term, final_sum;
  logic                 out_valid_r;
  logic [SW-1:0]        out_sum_r;
  logic [sat_pkg::STAT_W-1:0] out_stat_r;

  // table ports
  logic [sat_pkg::ADDR_W-1:0] raddr, waddr;
  logic [SW-1:0]        rdata, wdata;
  logic signed [RW-1:0] rsum_base, rsum_new;
  logic                 col_last, row_last;

  // unpacked input fields
  logic [EW-1:0] in_elem;
  logic [IW-1:0] in_rt, in_cl, in_rb, in_cr;

  assign in_elem = in_tdata[15:0];
  assign in_rt   = in_tdata[21:16];
  assign in_cl   = in_tdata[27:22];
  assign in_rb   = in_tdata[33:28];
  assign in_cr   = in_tdata[39:34];

  // clamp counts into 1..max
  always_comb begin
    rows = row_cnt_r;
    if (row_cnt_r == '0) begin
      rows = CW'(1);
    end else if (row_cnt_r > CW'(sat_pkg::MAX_ROWS)) begin
      rows = CW'(sat_pkg::MAX_ROWS);
    end
    cols = col_cnt_r;
    if (col_cnt_r == '0) begin
      cols = CW'(1);
    end else if (col_cnt_r > CW'(sat_pkg::MAX_COLS)) begin
      cols = CW'(sat_pkg::MAX_COLS);
    end
  end

  assign cfg_hit = cfg_valid &&
                   (cfg_index == sat_pkg::CFG_ROW_COUNT || cfg_index == sat_pkg::CFG_COL_COUNT);

  // query status from the incoming corners, not-ready check first
  always_comb begin
    if (!ready_r) begin
      qstat_nxt = sat_pkg::ST_NOT_READY;
    end else if (in_rt > in_rb || in_cl > in_cr ||
                 CW'(in_rb) >= rows || CW'(in_cr) >= cols) begin
      qstat_nxt = sat_pkg::ST_BAD_CORNER;
    end else begin
      qstat_nxt = sat_pkg::ST_OK;
    end
  end

  // table read address, entries at row or column minus one wrap and get masked
  always_comb begin
    unique case (cmd.rd_sel)
      sat_pkg::RD_ABOVE: raddr = {ld_row_r - IW'(1), ld_col_r};
      sat_pkg::RD_Q0:    raddr = {in_rb, in_cr};
      sat_pkg::RD_Q1:    raddr = {rt_r - IW'(1), cr_r};
      sat_pkg::RD_Q2:    raddr = {rb_r, cl_r - IW'(1)};
      sat_pkg::RD_Q3:    raddr = {rt_r - IW'(1), cl_r - IW'(1)};
      default:           raddr = {rb_r, cr_r};
    endcase
  end

  // running row sum and new prefix entry
  always_comb begin
    rsum_base = (ld_col_r == '0) ? '0 : rsum_r;
    rsum_new  = rsum_base + {{(RW-EW){elem_r[EW-1]}}, elem_r};
    wdata     = ((ld_row_r == '0) ? SW'(0) : rdata) + {{(SW-RW){rsum_new[RW-1]}}, rsum_new};
    waddr     = {ld_row_r, ld_col_r};
    col_last  = (CW'(ld_col_r) + CW'(1)) >= cols;
    row_last  = (CW'(ld_row_r) + CW'(1)) >= rows;
  end

  sat_ram #(
    .WIDTH (SW),
    .DEPTH (sat_pkg::DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.ld_write),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // signed, masked term for the read data arriving now
  always_comb begin
    unique case (cmd.acc_op)
      sat_pkg::ACC_T0: term = rdata;
      sat_pkg::ACC_T1: term = (rt_r != '0) ? -$signed(rdata) : '0;
      sat_pkg::ACC_T2: term = (cl_r != '0) ? -$signed(rdata) : '0;
      default:         term = (rt_r != '0 && cl_r != '0) ? $signed(rdata) : '0;
    endcase
    final_sum = (qstat_r == sat_pkg::ST_OK) ? acc_r + term : '0;
  end

  assign dp_stat.out_free = !out_valid_r || out_tready;

  // control state: counts, load position, ready flag, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= CW'(sat_pkg::MAX_ROWS);
      col_cnt_r   <= CW'(sat_pkg::MAX_COLS);
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      rsum_r      <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_hit) begin
        if (cfg_index == sat_pkg::CFG_ROW_COUNT) begin
          row_cnt_r <= cfg_data;
        end else begin
          col_cnt_r <= cfg_data;
        end
        ld_row_r <= '0;
        ld_col_r <= '0;
        rsum_r   <= '0;
        ready_r  <= 1'b0;
      end else if (cmd.ld_write) begin
        rsum_r <= rsum_new;
        if (col_last) begin
          ld_col_r <= '0;
          if (row_last) begin
            ld_row_r <= '0;
          end else begin
            ld_row_r <= ld_row_r + IW'(1);
          end
        end else begin
          ld_col_r <= ld_col_r + IW'(1);
        end
        // first element of a matrix clears ready, the last one sets it
        if (col_last && row_last) begin
          ready_r <= 1'b1;
        end else if (ld_row_r == '0 && ld_col_r == '0) begin
          ready_r <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      elem_r  <= in_elem;
      rt_r    <= in_rt;
      cl_r    <= in_cl;
      rb_r    <= in_rb;
      cr_r    <= in_cr;
      if (cmd.is_query) begin
        qstat_r <= qstat_nxt;
      end
    end
    unique case (cmd.acc_op)
      sat_pkg::ACC_T0: acc_r <= term;
      sat_pkg::ACC_T1: acc_r <= acc_r + term;
      sat_pkg::ACC_T2: acc_r <= acc_r + term;
      default:         acc_r <= acc_r;
    endcase
    if (cmd.out_load) begin
      out_sum_r  <= final_sum;
      out_stat_r <= qstat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(sat_pkg::OUT_DATA_W-SW){1'b0}}, out_sum_r};
  assign out_tuser  = out_stat_r;

endmodule : sat_datapath

`default_nettype wire

/* bench/testbench.sv */
// self-checking bench for the summed-area table query block: directed and random loads and queries
`timescale 1ns / 1ps

module testbench;

  // block constants taken from the package
  localparam int ELEM_W     = sat_pkg::ELEM_W;
  localparam int SUM_W      = sat_pkg::SUM_W;
  localparam int RSUM_W     = sat_pkg::RSUM_W;
  localparam int IDX_W      = sat_pkg::IDX_W;
  localparam int CNT_W      = sat_pkg::CNT_W;
  localparam int STAT_W     = sat_pkg::STAT_W;
  localparam int CFG_IDX_W  = sat_pkg::CFG_IDX_W;
  localparam int MAX_ROWS   = sat_pkg::MAX_ROWS;
  localparam int MAX_COLS   = sat_pkg::MAX_COLS;
  localparam int DEPTH      = sat_pkg::DEPTH;
  localparam int IN_DATA_W  = sat_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = sat_pkg::OUT_DATA_W;
  localparam logic [STAT_W-1:0]    ST_OK         = sat_pkg::ST_OK;
  localparam logic [STAT_W-1:0]    ST_NOT_READY  = sat_pkg::ST_NOT_READY;
  localparam logic [STAT_W-1:0]    ST_BAD_CORNER = sat_pkg::ST_BAD_CORNER;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = sat_pkg::CFG_ROW_COUNT;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = sat_pkg::CFG_COL_COUNT;
  localparam logic                 REQ_LOAD      = sat_pkg::REQ_LOAD;
  localparam logic                 REQ_QUERY     = sat_pkg::REQ_QUERY;

  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASES        = 24;

  // bit positions of the query corners inside in_tdata
  localparam int RT_LSB = ELEM_W;
  localparam int CL_LSB = ELEM_W + IDX_W;
  localparam int RB_LSB = ELEM_W + 2 * IDX_W;
  localparam int CR_LSB = ELEM_W + 3 * IDX_W;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum int {FILL_RANDOM, FILL_MIN, FILL_MAX} fill_kind_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic [STAT_W-1:0]       status;
  } rect_answer_t;

  // running copy of the table and the answers still owed by the block
  class rect_sum_board;
    logic signed [SUM_W-1:0]  prefix_sums [DEPTH];
    logic signed [RSUM_W-1:0] row_acc;
    logic [CNT_W-1:0]         next_row, next_col;
    logic                     ready;
    logic [CNT_W-1:0]         row_reg, col_reg;
    rect_answer_t             pending_sums [$];
    int                       mismatches;

    function new();
      foreach (prefix_sums[i]) prefix_sums[i] = '0;
      row_acc    = '0;
      next_row   = '0;
      next_col   = '0;
      ready      = 1'b0;
      row_reg    = CNT_W'(MAX_ROWS);
      col_reg    = CNT_W'(MAX_COLS);
      mismatches = 0;
    endfunction

    // zero acts as one, anything above the maximum as the maximum
    function int unsigned eff_count(logic [CNT_W-1:0] v, int unsigned maxv);
      if (v == '0) return 1;
      if (32'(v) > maxv) return maxv;
      return 32'(v);
    endfunction

    // entries left of column 0 or above row 0 read as zero
    function logic signed [SUM_W-1:0] read_entry(int r, int c);
      if (r < 0 || c < 0) return '0;
      return prefix_sums[r * MAX_COLS + c];
    endfunction

    function int pending();
      return pending_sums.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
    endfunction

    function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
      if (idx == CFG_ROW_COUNT) row_reg = val;
      else if (idx == CFG_COL_COUNT) col_reg = val;
      else return;
      next_row = '0;
      next_col = '0;
      row_acc  = '0;
      ready    = 1'b0;
    endfunction

    function void take_item(logic req, logic [IN_DATA_W-1:0] data);
      int unsigned rows, cols;
      logic signed [ELEM_W-1:0] e;
      int rt, cl, rb, cr;
      rect_answer_t a;
      rows = eff_count(row_reg, MAX_ROWS);
      cols = eff_count(col_reg, MAX_COLS);
      // load: extend the row sum and add the entry above
      if (req == REQ_LOAD) begin
        e = data[ELEM_W-1:0];
        if (next_row == '0 && next_col == '0) ready = 1'b0;
        if (next_col == '0) row_acc = '0;
        row_acc = row_acc + RSUM_W'(e);
        prefix_sums[next_row * MAX_COLS + next_col] =
          read_entry(int'(next_row) - 1, int'(next_col)) + SUM_W'(row_acc);
        next_col++;
        if (32'(next_col) >= cols) begin
          next_col = '0;
          next_row++;
          if (32'(next_row) >= rows) begin
            next_row = '0;
            ready    = 1'b1;
          end
        end
        return;
      end
      // query: readiness first, then the corners
      rt = int'(data[RT_LSB +: IDX_W]);
      cl = int'(data[CL_LSB +: IDX_W]);
      rb = int'(data[RB_LSB +: IDX_W]);
      cr = int'(data[CR_LSB +: IDX_W]);
      a.sum    = '0;
      a.status = ST_OK;
      if (!ready) begin
        a.status = ST_NOT_READY;
      end else if (rt > rb || cl > cr || rb >= rows || cr >= cols) begin
        a.status = ST_BAD_CORNER;
      end else begin
        a.sum = read_entry(rb, cr) - read_entry(rt - 1, cr)
              - read_entry(rb, cl - 1) + read_entry(rt - 1, cl - 1);
      end
      pending_sums.push_back(a);
    endfunction

    function void check_answer(logic [OUT_DATA_W-1:0] data, logic [STAT_W-1:0] st);
      rect_answer_t want;
      if (pending_sums.size() == 0) begin
        flag($sformatf("result with no query pending: sum %0d status %0d",
                       $signed(data[SUM_W-1:0]), st));
        return;
      end
      want = pending_sums.pop_front();
      if (data[SUM_W-1:0] !== want.sum)
        flag($sformatf("region_sum expected %0d got %0d", want.sum, $signed(data[SUM_W-1:0])));
      if (data[OUT_DATA_W-1:SUM_W] !== '0)
        flag($sformatf("tdata fill expected 0 got %h", data[OUT_DATA_W-1:SUM_W]));
      if (st !== want.status)
        flag($sformatf("status expected %0d got %0d", want.status, st));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [STAT_W-1:0]      out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CNT_W-1:0]       cfg_data = '0;

  rect_sum_board sb;
  int sender_idle_pct = 21;
  int receiver_idle_pct = 59;
  int cycle_count = 0;

  summed_area_table_query dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99, 0) >= receiver_idle_pct);
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_answer(out_tdata, out_tuser);
  end

  // one item on the input channel, entered and left at a falling edge
  task automatic send_item(input logic req, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_item(req, data);
    @(negedge clk);
  endtask

  task automatic send_load(input logic [ELEM_W-1:0] e);
    logic [IN_DATA_W-1:0] w;
    w = IN_DATA_W'({$urandom, $urandom});
    w[ELEM_W-1:0] = e;
    send_item(REQ_LOAD, w);
  endtask

  task automatic send_query(input int rt, input int cl, input int rb, input int cr);
    logic [IN_DATA_W-1:0] w;
    w = IN_DATA_W'({$urandom, $urandom});
    w[RT_LSB +: IDX_W] = IDX_W'(rt);
    w[CL_LSB +: IDX_W] = IDX_W'(cl);
    w[RB_LSB +: IDX_W] = IDX_W'(rb);
    w[CR_LSB +: IDX_W] = IDX_W'(cr);
    send_item(REQ_QUERY, w);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_register(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold the sender until every answer is in and the last load has settled
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [ELEM_W-1:0] pick_element(input fill_kind_t fill);
    int k;
    if (fill == FILL_MIN) return {1'b1, {(ELEM_W-1){1'b0}}};
    if (fill == FILL_MAX) return {1'b0, {(ELEM_W-1){1'b1}}};
    k = $urandom_range(99, 0);
    if (k < 8) return {1'b1, {(ELEM_W-1){1'b0}}};
    if (k < 16) return {1'b0, {(ELEM_W-1){1'b1}}};
    if (k < 20) return '0;
    return ELEM_W'($urandom);
  endfunction

  task automatic load_elements(input int n, input fill_kind_t fill);
    repeat (n) send_load(pick_element(fill));
  endtask

  // mostly well-formed rectangles, the rest broken or raw corners
  task automatic random_query(input int rows, input int cols);
    int k, rt, cl, rb, cr;
    k  = $urandom_range(99, 0);
    rt = $urandom_range(rows - 1, 0);
    rb = $urandom_range(rows - 1, rt);
    cl = $urandom_range(cols - 1, 0);
    cr = $urandom_range(cols - 1, cl);
    if (k < 6 && rows > 1) begin
      rb = $urandom_range(rows - 2, 0);
      rt = $urandom_range(rows - 1, rb + 1);
    end else if (k < 12 && cols > 1) begin
      cr = $urandom_range(cols - 2, 0);
      cl = $urandom_range(cols - 1, cr + 1);
    end else if (k < 17 && rows < MAX_ROWS) begin
      rb = $urandom_range(MAX_ROWS - 1, rows);
    end else if (k < 22 && cols < MAX_COLS) begin
      cr = $urandom_range(MAX_COLS - 1, cols);
    end else if (k < 27) begin
      rt = $urandom_range(MAX_ROWS - 1, 0);
      cl = $urandom_range(MAX_COLS - 1, 0);
      rb = $urandom_range(MAX_ROWS - 1, 0);
      cr = $urandom_range(MAX_COLS - 1, 0);
    end else if (k < 32) begin
      rb = rt;
      cr = cl;
    end
    send_query(rt, cl, rb, cr);
  endtask

  // one setting: write the sizes, fill a matrix with a query part way, then ask
  task automatic run_phase(input logic [CNT_W-1:0] row_val, input logic [CNT_W-1:0] col_val,
                           input fill_kind_t fill);
    int rows, cols, cells, split, n;
    drain();
    if ($urandom_range(1, 0)) begin
      write_register(CFG_ROW_COUNT, row_val);
      write_register(CFG_COL_COUNT, col_val);
    end else begin
      write_register(CFG_COL_COUNT, col_val);
      write_register(CFG_ROW_COUNT, row_val);
    end
    rows  = sb.eff_count(row_val, MAX_ROWS);
    cols  = sb.eff_count(col_val, MAX_COLS);
    cells = rows * cols;
    n = $urandom_range(2, 0);
    repeat (n) random_query(rows, cols);
    split = $urandom_range(cells - 1, 0);
    load_elements(split, fill);
    if (split > 0) random_query(rows, cols);
    load_elements(cells - split, fill);
    send_query(0, 0, rows - 1, cols - 1);
    n = $urandom_range(10, 4);
    repeat (n) random_query(rows, cols);
    if (cells > 64) return;
    // a second matrix over the first
    if ($urandom_range(3, 0) == 0) begin
      split = $urandom_range(cells - 1, 0);
      load_elements(split, fill);
      random_query(rows, cols);
      load_elements(cells - split, fill);
      n = $urandom_range(10, 4);
      repeat (n) random_query(rows, cols);
    end
    // a matrix left half loaded for the next register write to cut off
    if (cells > 1 && $urandom_range(3, 0) == 0) begin
      load_elements($urandom_range(cells - 1, 1), fill);
      random_query(rows, cols);
    end
  endtask

  initial begin
    int phase;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: nothing loaded yet, readiness beats bad corners
    send_query(0, 0, MAX_ROWS - 1, MAX_COLS - 1);
    send_query(MAX_ROWS - 1, MAX_COLS - 1, 0, 0);
    drain();
    write_register(CFG_ROW_COUNT, 7'd2);
    write_register(CFG_COL_COUNT, 7'd3);
    send_load(16'h7fff);
    send_load(16'h8000);
    send_load(16'h0000);
    send_load(16'hffff);
    send_load(16'h0001);
    send_load(16'h7fff);
    send_query(0, 0, 1, 2);
    send_query(1, 2, 1, 2);
    send_query(0, 0, 0, 0);
    send_query(0, 1, 1, 1);
    // inverted rows, inverted columns, rows and columns beyond the size
    send_query(1, 0, 0, 2);
    send_query(0, 2, 1, 1);
    send_query(0, 0, 2, 0);
    send_query(0, 0, 0, 3);
    send_query(MAX_ROWS - 1, MAX_COLS - 1, MAX_ROWS - 1, MAX_COLS - 1);
    // a load at the origin starts a new matrix and drops readiness
    send_load(16'h8000);
    send_query(0, 0, 0, 0);
    load_elements(5, FILL_MIN);
    send_query(0, 0, 1, 2);

    // random settings, idling regime changes by thirds
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES / 3) begin
        sender_idle_pct   = 59;
        receiver_idle_pct = 21;
      end else if (phase == 2 * PHASES / 3) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      case (phase)
        1: run_phase(7'd0, 7'd0, FILL_RANDOM);
        3: begin
          run_phase(7'd64, 7'd2, FILL_MIN);
          run_phase(7'd2, 7'd64, FILL_MAX);
        end
        6: run_phase(7'd127, 7'd1, FILL_RANDOM);
        12: run_phase(7'd1, 7'd127, FILL_RANDOM);
        15: run_phase(7'd65, 7'd1, FILL_RANDOM);
        21: run_phase(7'd1, 7'd1, FILL_MAX);
        default: run_phase(CNT_W'($urandom_range(6, 1)), CNT_W'($urandom_range(6, 1)),
                           FILL_RANDOM);
      endcase
      // writes to unused indexes must leave sizes and table alone
      if (phase == 8 || phase == 19) begin
        drain();
        write_register(phase == 8 ? CFG_SPARE_A : CFG_SPARE_B, CNT_W'($urandom));
        repeat (6) random_query(sb.eff_count(sb.row_reg, MAX_ROWS),
                                sb.eff_count(sb.col_reg, MAX_COLS));
      end
    end

    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.pending() == 0 && sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/sat_pkg.sv
hdl/sat_ram.sv
hdl/sat_ctrl.sv
hdl/sat_datapath.sv
hdl/summed_area_table_query.sv
bench/testbench.sv
